// ===== rtl/lps_pkg.sv =====
// Shared types, sizes and LCD byte codes for the LCD pixel shadow update block.
`timescale 1ns / 1ps
`default_nettype none
package lps_pkg;

   // Display geometry
   localparam int COLUMNS = 84;
   localparam int ROWS    = 48;
   localparam int BANKS   = (ROWS + 7) / 8;
   localparam int ROW_W   = BANKS * 8;                          // one shadow row = one column
   localparam int COL_W   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int Y_IDX_W = 6;                                  // row bit index, ROWS <= 64
   localparam int STEP_W  = 4;                                  // up to 3 + 8 bytes

   // Request actions
   localparam logic [1:0] ACT_SET   = 2'd0;
   localparam logic [1:0] ACT_CLEAR = 2'd1;
   localparam logic [1:0] ACT_LINE  = 2'd2;

   // LCD byte codes
   localparam logic [7:0] LCD_FUNC_VERT = 8'd34;   // function set, vertical addressing
   localparam logic [7:0] LCD_SET_Y     = 8'h40;
   localparam logic [7:0] LCD_SET_X     = 8'h80;
   localparam logic [7:0] LCD_FULL      = 8'hFF;

   // Step of the final byte of each request type
   localparam logic [STEP_W-1:0] PIX_LAST  = STEP_W'(2);
   localparam logic [STEP_W-1:0] LINE_LAST = STEP_W'(BANKS + 2);

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] x_pos;
      logic [7:0] y_pos;
   } req_type;

   typedef struct packed {
      logic [7:0] lcd_byte;
      logic       is_data;
      logic       status;
      logic       last;
   } rsp_type;

   // Controller -> datapath
   typedef struct packed {
      logic              load;    // capture request, start shadow row read
      logic              write;   // update shadow row
      logic              emit;    // load output register
      logic [STEP_W-1:0] step;    // byte number within the request
   } ctl_cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic req_ok;     // incoming request is in range
      logic out_free;   // output register can take a byte
      logic is_last;    // current step is the final byte
   } dp_sts_type;

endpackage
`default_nettype wire

// ===== rtl/lps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module lps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/lps_ctrl.sv =====
// Request sequencer: accepts a request, triggers the shadow update for an in-range request, steps the byte stream.
`timescale 1ns / 1ps
`default_nettype none
module lps_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_ready,
   input  wire lps_pkg::dp_sts_type sts,
   output      lps_pkg::ctl_cmd_type cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_MOD,
      S_EMIT
   } state_type;

   state_type                    state_ff, state_in;
   logic [lps_pkg::STEP_W-1:0]   step_ff, step_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd.load  = (state_ff == S_IDLE) && req_valid;
      cmd.write = (state_ff == S_MOD);
      cmd.emit  = (state_ff != S_IDLE) && sts.out_free;
      cmd.step  = step_ff;
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               step_in  = '0;
               state_in = sts.req_ok ? S_MOD : S_EMIT;
            end
         end
         S_MOD: begin
            // first byte is never the last one for a valid request
            state_in = S_EMIT;
            if (sts.out_free) begin
               step_in = step_ff + 1'b1;
            end
         end
         S_EMIT: begin
            if (sts.out_free) begin
               if (sts.is_last) begin
                  state_in = S_IDLE;
                  step_in  = '0;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
            step_in  = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != S_IDLE))
      else $error("accepted request did not start a sequence");

   a_step_bounded: assert property (@(posedge clock) disable iff (reset)
      step_ff <= lps_pkg::LINE_LAST)
      else $error("byte step ran past the longest request");

   a_bad_skips_write: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && !sts.req_ok) |=> (state_ff == S_EMIT) && (step_ff == '0))
      else $error("out of range request entered the update state");

endmodule
`default_nettype wire

// ===== rtl/lps_dp.sv =====
// Datapath: request capture, column-row shadow RAM, byte formatting and output register.
`timescale 1ns / 1ps
`default_nettype none
module lps_dp (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lps_pkg::req_type     req_payload,
   input  wire lps_pkg::ctl_cmd_type cmd,
   output      lps_pkg::dp_sts_type  sts,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   output      lps_pkg::rsp_type     rsp_payload
);

   localparam logic [lps_pkg::STEP_W-1:0] STEP0 = lps_pkg::STEP_W'(0);
   localparam logic [lps_pkg::STEP_W-1:0] STEP1 = lps_pkg::STEP_W'(1);
   localparam logic [lps_pkg::STEP_W-1:0] STEP2 = lps_pkg::STEP_W'(2);

   lps_pkg::req_type            req_ff;
   logic                        ok_ff;
   logic [lps_pkg::COLUMNS-1:0] row_valid_ff, row_valid_in;
   logic [7:0]                  byte_ff, byte_in;
   lps_pkg::rsp_type            rsp_ff, rsp_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   logic                        req_ok;
   logic                        x_ok;
   logic [lps_pkg::COL_W-1:0]   col;
   logic [lps_pkg::ROW_W-1:0]   row_rd;
   logic [lps_pkg::ROW_W-1:0]   row_base;
   logic [lps_pkg::ROW_W-1:0]   row_new;
   logic [2:0]                  bank;
   logic                        is_line;

   // Range check of the request at the port
   always_comb begin
      x_ok = (req_payload.x_pos < 8'(lps_pkg::COLUMNS));
      case (req_payload.action) inside
         lps_pkg::ACT_SET, lps_pkg::ACT_CLEAR:
            req_ok = x_ok && (req_payload.y_pos < 8'(lps_pkg::ROWS));
         lps_pkg::ACT_LINE:
            req_ok = x_ok;
         default:
            req_ok = 1'b0;
      endcase
   end

   // One RAM word holds a whole column, all banks
   lps_ram #(
      .WIDTH (lps_pkg::ROW_W),
      .DEPTH (lps_pkg::COLUMNS)
   ) u_shadow (
      .clock   (clock),
      .wr_en   (cmd.write),
      .wr_addr (col),
      .wr_data (row_new),
      .rd_en   (cmd.load && req_ok),
      .rd_addr (req_payload.x_pos[lps_pkg::COL_W-1:0]),
      .rd_data (row_rd)
   );

   assign col     = req_ff.x_pos[lps_pkg::COL_W-1:0];
   assign bank    = req_ff.y_pos[5:3];
   assign is_line = (req_ff.action == lps_pkg::ACT_LINE);

   always_comb begin
      row_base = row_valid_ff[col] ? row_rd : '0;
      row_new  = row_base;
      if (is_line) begin
         row_new = '1;
      end else begin
         row_new[req_ff.y_pos[lps_pkg::Y_IDX_W-1:0]] = (req_ff.action == lps_pkg::ACT_SET);
      end
   end

   always_comb begin
      row_valid_in = row_valid_ff;
      byte_in      = byte_ff;
      if (cmd.write) begin
         row_valid_in[col] = 1'b1;
         byte_in           = row_new[{bank, 3'b000} +: 8];
      end
   end

   // Byte formatting by step
   always_comb begin
      rsp_in = '0;
      if (!ok_ff) begin
         rsp_in.status = 1'b1;
         rsp_in.last   = 1'b1;
      end else if (is_line) begin
         case (cmd.step)
            STEP0:   rsp_in.lcd_byte = lps_pkg::LCD_FUNC_VERT;
            STEP1:   rsp_in.lcd_byte = lps_pkg::LCD_SET_Y;
            STEP2:   rsp_in.lcd_byte = lps_pkg::LCD_SET_X + req_ff.x_pos;
            default: begin
               rsp_in.lcd_byte = lps_pkg::LCD_FULL;
               rsp_in.is_data  = 1'b1;
            end
         endcase
         rsp_in.last = (cmd.step == lps_pkg::LINE_LAST);
      end else begin
         case (cmd.step)
            STEP0:   rsp_in.lcd_byte = lps_pkg::LCD_SET_X | req_ff.x_pos;
            STEP1:   rsp_in.lcd_byte = lps_pkg::LCD_SET_Y | {5'b00000, bank};
            default: begin
               rsp_in.lcd_byte = byte_ff;
               rsp_in.is_data  = 1'b1;
            end
         endcase
         rsp_in.last = (cmd.step == lps_pkg::PIX_LAST);
      end
   end

   assign rsp_valid_in = cmd.emit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_payload;
         ok_ff  <= req_ok;
      end
      byte_ff <= byte_in;
      if (cmd.emit) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_valid_ff <= row_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign sts.req_ok   = req_ok;
   assign sts.out_free = !rsp_valid_ff || rsp_ready;
   assign sts.is_last  = rsp_in.last;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_single_write: assert property (@(posedge clock) disable iff (reset)
      cmd.write |=> !cmd.write)
      else $error("shadow row written twice for one request");

   a_bad_byte_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status) |-> (rsp_ff.last && (rsp_ff.lcd_byte == 8'h00)
                                           && !rsp_ff.is_data))
      else $error("error result carries a byte");

   a_write_marks_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.write |=> row_valid_ff[$past(col)])
      else $error("written shadow row not marked valid");

endmodule
`default_nettype wire

// ===== rtl/lcd_pixel_shadow_update.sv =====
// Top level: shadow-buffered pixel / vertical line writer producing an LCD byte stream.
//
//  channel  direction  handshake             payload
//  req      in         req_valid/req_ready   lps_pkg::req_type  {action, x_pos, y_pos}
//  rsp      out        rsp_valid/rsp_ready   lps_pkg::rsp_type  {lcd_byte, is_data, status, last}
//
// One request is in flight at a time. A pixel request is accepted, does a shadow
// read-modify-write, then sends its bytes at one byte per cycle while rsp does not stall;
// a vertical line sends 3 + BANKS bytes likewise, and an out of range request one status byte.
// The shadow RAM holds one column per word; per-column valid bits cleared by reset make
// the whole shadow read as blank right after reset, so no clearing pass is needed.
// The output register takes a new byte only when empty or being read, so rsp stalls hold
// the sequencer; the next request is accepted while the final byte still waits.
`timescale 1ns / 1ps
`default_nettype none
module lcd_pixel_shadow_update (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_ready,
   input  wire lps_pkg::req_type req_payload,
   output      logic             rsp_valid,
   input  wire logic             rsp_ready,
   output      lps_pkg::rsp_type rsp_payload
);

   // command and status between the sequencer and the datapath
   lps_pkg::ctl_cmd_type cmd;
   lps_pkg::dp_sts_type  sts;

   // sequencer: idle -> update (write shadow, first byte) -> emit bytes -> idle; out of range: idle -> emit
   lps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: request register, shadow RAM, byte mux, output register
   lps_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire

// ===== tb/lcd_pixel_shadow_update_tb.sv =====
// Self-checking testbench for the LCD pixel shadow update block.
`timescale 1ns / 1ps
module lcd_pixel_shadow_update_tb;
   import lps_pkg::*;

   // Action code that the block does not know; it must be answered as invalid.
   localparam logic [1:0] ACT_UNKNOWN = 2'd3;
   localparam int DRAIN_CYCLES = 16;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_PER_PHASE = 78;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   // Requests waiting for the driver, and LCD bytes the block still owes.
   req_type    pending_requests[$];
   rsp_type    expected_bytes[$];
   // Shadow copy of the display: one byte per column and bank.
   logic [7:0] shadow_copy[COLUMNS * BANKS];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int error_count    = 0;
   int cycle_count    = 0;

   lcd_pixel_shadow_update DUT (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Work out the byte stream of one accepted request and update the shadow copy.
   task automatic predict_lcd_stream(input req_type r);
      rsp_type    b;
      logic [7:0] mask;
      int         bank;
      int         idx;
      if ((r.action == ACT_SET || r.action == ACT_CLEAR)
          && r.x_pos < COLUMNS && r.y_pos < ROWS) begin
         bank = r.y_pos / 8;
         idx  = r.x_pos * BANKS + bank;
         mask = 8'(1) << r.y_pos[2:0];
         if (r.action == ACT_SET) begin
            shadow_copy[idx] = shadow_copy[idx] | mask;
         end else begin
            shadow_copy[idx] = shadow_copy[idx] & ~mask;
         end
         b = '{lcd_byte: LCD_SET_X | r.x_pos, is_data: 1'b0, status: 1'b0, last: 1'b0};
         expected_bytes.push_back(b);
         b = '{lcd_byte: LCD_SET_Y | 8'(bank), is_data: 1'b0, status: 1'b0, last: 1'b0};
         expected_bytes.push_back(b);
         b = '{lcd_byte: shadow_copy[idx], is_data: 1'b1, status: 1'b0, last: 1'b1};
         expected_bytes.push_back(b);
      end else if (r.action == ACT_LINE && r.x_pos < COLUMNS) begin
         // Vertical addressing, home to bank 0 of the column, then fill it.
         b = '{lcd_byte: LCD_FUNC_VERT, is_data: 1'b0, status: 1'b0, last: 1'b0};
         expected_bytes.push_back(b);
         b = '{lcd_byte: LCD_SET_Y, is_data: 1'b0, status: 1'b0, last: 1'b0};
         expected_bytes.push_back(b);
         b = '{lcd_byte: LCD_SET_X + r.x_pos, is_data: 1'b0, status: 1'b0, last: 1'b0};
         expected_bytes.push_back(b);
         for (bank = 0; bank < BANKS; bank++) begin
            shadow_copy[r.x_pos * BANKS + bank] = LCD_FULL;
            b = '{lcd_byte: LCD_FULL, is_data: 1'b1, status: 1'b0,
                  last: (bank == BANKS - 1)};
            expected_bytes.push_back(b);
         end
      end else begin
         // Out of range or unknown action: one status byte, shadow untouched.
         b = '{lcd_byte: 8'h00, is_data: 1'b0, status: 1'b1, last: 1'b1};
         expected_bytes.push_back(b);
      end
   endtask

   // Mostly legal pixel and line requests; pixels often land in a small corner so
   // that bits pile up in the same shadow bytes. The rest is out of range or garbage.
   function automatic req_type random_request();
      req_type r;
      int      pick;
      pick = $urandom_range(99);
      r.y_pos = 8'($urandom_range(255));
      if (pick < 80) begin
         r.action = (pick < 45) ? ACT_SET : ACT_CLEAR;
         if ($urandom_range(1) == 1) begin
            r.x_pos = 8'($urandom_range(7));
            r.y_pos = 8'($urandom_range(15));
         end else begin
            r.x_pos = 8'($urandom_range(COLUMNS - 1));
            r.y_pos = 8'($urandom_range(ROWS - 1));
         end
      end else if (pick < 88) begin
         r.action = ACT_LINE;
         r.x_pos  = 8'($urandom_range(COLUMNS - 1));
      end else begin
         case ($urandom_range(3))
            0: begin
               r.action = ($urandom_range(1) == 1) ? ACT_SET : ACT_CLEAR;
               r.x_pos  = 8'($urandom_range(255, COLUMNS));
            end
            1: begin
               r.action = ($urandom_range(1) == 1) ? ACT_SET : ACT_CLEAR;
               r.x_pos  = 8'($urandom_range(COLUMNS - 1));
               r.y_pos  = 8'($urandom_range(255, ROWS));
            end
            2: begin
               r.action = ACT_LINE;
               r.x_pos  = 8'($urandom_range(255, COLUMNS));
            end
            default: begin
               r.action = ACT_UNKNOWN;
               r.x_pos  = 8'($urandom_range(255));
            end
         endcase
      end
      return r;
   endfunction

   // Driver: predicts on every accepted request, then offers the next one when the
   // slot is free and the idle dice allow. Payload is held while valid waits.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_lcd_stream(req_payload);
         end
         if (!req_valid || req_ready) begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid   <= 1'b1;
               req_payload <= pending_requests.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compares every accepted byte with the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               $error("unexpected LCD byte %02h (is_data %0b status %0b last %0b)",
                      rsp_payload.lcd_byte, rsp_payload.is_data,
                      rsp_payload.status, rsp_payload.last);
               error_count++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_payload.lcd_byte !== want.lcd_byte) begin
                  $error("lcd_byte: expected %02h, got %02h",
                         want.lcd_byte, rsp_payload.lcd_byte);
                  error_count++;
               end
               if (rsp_payload.is_data !== want.is_data) begin
                  $error("is_data: expected %0b, got %0b", want.is_data, rsp_payload.is_data);
                  error_count++;
               end
               if (rsp_payload.status !== want.status) begin
                  $error("status: expected %0b, got %0b", want.status, rsp_payload.status);
                  error_count++;
               end
               if (rsp_payload.last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_payload.last);
                  error_count++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("lcd_pixel_shadow_update regression: fail");
         $finish;
      end
   end

   task automatic queue_request(input logic [1:0] a, input int x, input int y);
      req_type r;
      r.action = a;
      r.x_pos  = 8'(x);
      r.y_pos  = 8'(y);
      pending_requests.push_back(r);
   endtask

   // Hold the sender back until the block has delivered everything it owes.
   task automatic wait_for_idle();
      while (pending_requests.size() > 0 || req_valid || expected_bytes.size() > 0) begin
         @(posedge clock);
      end
   endtask

   task automatic run_random_phase(input int idle_pct, input int stall_pct, input int count);
      int n;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (n = 0; n < count; n++) begin
         pending_requests.push_back(random_request());
      end
      wait_for_idle();
   endtask

   initial begin
      int n;
      for (n = 0; n < COLUMNS * BANKS; n++) begin
         shadow_copy[n] = 8'h00;
      end

      // Directed requests: corners of the screen, every action, range edges.
      queue_request(ACT_SET,   0, 0);
      queue_request(ACT_SET,   COLUMNS - 1, ROWS - 1);
      queue_request(ACT_CLEAR, COLUMNS - 1, ROWS - 1);
      queue_request(ACT_CLEAR, 0, 0);
      queue_request(ACT_SET,   COLUMNS - 1, 0);
      queue_request(ACT_SET,   0, ROWS - 1);
      // several bits in one byte, set twice, then cleared
      queue_request(ACT_SET,   10, 8);
      queue_request(ACT_SET,   10, 9);
      queue_request(ACT_SET,   10, 15);
      queue_request(ACT_SET,   10, 15);
      queue_request(ACT_CLEAR, 10, 8);
      queue_request(ACT_CLEAR, 10, 12);
      // out of range column, row, both; unknown action
      queue_request(ACT_SET,   COLUMNS, 0);
      queue_request(ACT_CLEAR, 0, ROWS);
      queue_request(ACT_SET,   255, 255);
      queue_request(ACT_UNKNOWN, 5, 5);
      queue_request(ACT_UNKNOWN, 255, 255);
      // vertical lines at both edges and beyond; row is ignored
      queue_request(ACT_LINE,  0, 0);
      queue_request(ACT_LINE,  COLUMNS - 1, 255);
      queue_request(ACT_LINE,  COLUMNS, 0);
      queue_request(ACT_LINE,  255, 255);
      // pixels on a filled column read back the full byte, less any cleared bit
      queue_request(ACT_SET,   0, 5);
      queue_request(ACT_CLEAR, COLUMNS - 1, 10);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // no idling, sender idle, receiver stalling, then both
      run_random_phase(0, 0, RANDOM_PER_PHASE);
      run_random_phase(60, 0, RANDOM_PER_PHASE);
      run_random_phase(0, 60, RANDOM_PER_PHASE);
      run_random_phase(14, 14, RANDOM_PER_PHASE + 10);

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_bytes.size() > 0) begin
         $error("%0d expected LCD bytes never arrived", expected_bytes.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("lcd_pixel_shadow_update regression: pass");
      end else begin
         $display("lcd_pixel_shadow_update regression: fail");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/lps_pkg.sv
rtl/lps_ram.sv
rtl/lps_ctrl.sv
rtl/lps_dp.sv
rtl/lcd_pixel_shadow_update.sv
tb/lcd_pixel_shadow_update_tb.sv
